// File: src/shortest_arc_quaternion_assert.svh
// ----------------------------------------------------------------------------
// shortest arc quaternion assertion macros
// same-cycle and next-cycle implication checks on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SHORTEST_ARC_QUATERNION_ASSERT_SVH
`define SHORTEST_ARC_QUATERNION_ASSERT_SVH

// same-cycle implication
`define SAQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/saq_pkg.sv
// ----------------------------------------------------------------------------
// saq_pkg
// types and constants of the shortest arc quaternion pipeline
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int COMP_W = 32;
  localparam int LANE_W = 33;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int QUOT_W = 32;
  localparam int FRAC   = 30;
  localparam int LANES  = 3;

  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
  localparam logic signed [33:0] OPP_LIM  = -34'sd1073741824 + 34'sd1073742;
  localparam logic signed [33:0] COS_MAX  = 34'sd1073741824;
  localparam logic [63:0]        AXIS_MIN = 64'd11529215046068470;
  localparam logic signed [63:0] RND_HALF = 64'sd536870912;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dest_x;
    logic signed [31:0] dest_y;
    logic signed [31:0] dest_z;
  } saq_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               opposite_case;
    logic               zero_length;
  } saq_out_t;

endpackage

// File: src/saq_isqrt.sv
// ----------------------------------------------------------------------------
// saq_isqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module saq_isqrt #(
  parameter int SBW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [saq_pkg::RAD_W-1:0]  in_rad,
  input  logic [SBW-1:0]             in_sb,
  output logic                       out_vld,
  output logic [saq_pkg::ROOT_W-1:0] out_root,
  output logic [SBW-1:0]             out_sb
);

  localparam int STEPS = saq_pkg::ROOT_W;
  localparam int RW    = saq_pkg::RAD_W;
  localparam int CW    = saq_pkg::RAD_W + 2;

  logic                       vld_r  [STEPS];
  logic [RW-1:0]              rem_r  [STEPS];
  logic [saq_pkg::ROOT_W-1:0] root_r [STEPS];
  logic [SBW-1:0]             sb_r   [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    localparam int K = STEPS - 1 - g;
    logic                       vld_src;
    logic [RW-1:0]              rem_src;
    logic [saq_pkg::ROOT_W-1:0] root_src;
    logic [SBW-1:0]             sb_src;
    logic [CW-1:0]              cand;
    logic                       ge;

    if (g == 0) begin : g_first
      assign vld_src  = in_vld;
      assign rem_src  = in_rad;
      assign root_src = '0;
      assign sb_src   = in_sb;
    end else begin : g_next
      assign vld_src  = vld_r[g-1];
      assign rem_src  = rem_r[g-1];
      assign root_src = root_r[g-1];
      assign sb_src   = sb_r[g-1];
    end

    assign cand = (CW'(root_src) << (K + 1)) + (CW'(1) << (2 * K));
    assign ge   = CW'(rem_src) >= cand;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? rem_src - cand[RW-1:0] : rem_src;
        root_r[g] <= ge ? (root_src | (saq_pkg::ROOT_W'(1) << K)) : root_src;
        sb_r[g]   <= sb_src;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1];
  assign out_sb   = sb_r[STEPS-1];

endmodule

// File: src/saq_div3.sv
// ----------------------------------------------------------------------------
// saq_div3
// three-lane pipelined restoring divider, rounded (n * 2^30 + d/2) / d
// ----------------------------------------------------------------------------
module saq_div3 #(
  parameter int SBW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [saq_pkg::LANE_W-1:0] in_num [saq_pkg::LANES],
  input  logic [saq_pkg::ROOT_W-1:0] in_den,
  input  logic [SBW-1:0]             in_sb,
  output logic                       out_vld,
  output logic [saq_pkg::QUOT_W-1:0] out_quot [saq_pkg::LANES],
  output logic [saq_pkg::LANES-1:0]  out_ovf,
  output logic [SBW-1:0]             out_sb
);

  localparam int STEPS = saq_pkg::QUOT_W;
  localparam int RW    = saq_pkg::RAD_W;
  localparam int NL    = saq_pkg::LANES;

  logic                       pre_vld_r;
  logic [RW-1:0]              pre_rem_r [NL];
  logic [NL-1:0]              pre_ovf_r;
  logic [saq_pkg::ROOT_W-1:0] pre_den_r;
  logic [SBW-1:0]             pre_sb_r;
  logic [RW-1:0]              pre_nxt   [NL];
  logic [NL-1:0]              ovf_nxt;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      pre_nxt[i] = (RW'(in_num[i]) << saq_pkg::FRAC) + RW'(in_den >> 1);
      ovf_nxt[i] = (RW + 1)'(pre_nxt[i]) >= ((RW + 1)'(in_den) << STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_rem_r <= pre_nxt;
      pre_ovf_r <= ovf_nxt;
      pre_den_r <= in_den;
      pre_sb_r  <= in_sb;
    end
  end

  logic                       vld_r  [STEPS];
  logic [RW-1:0]              rem_r  [STEPS][NL];
  logic [saq_pkg::QUOT_W-1:0] quot_r [STEPS][NL];
  logic [NL-1:0]              ovf_r  [STEPS];
  logic [saq_pkg::ROOT_W-1:0] den_r  [STEPS];
  logic [SBW-1:0]             sb_r   [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    localparam int K = STEPS - 1 - g;
    logic                       vld_src;
    logic [RW-1:0]              rem_src  [NL];
    logic [saq_pkg::QUOT_W-1:0] quot_src [NL];
    logic [NL-1:0]              ovf_src;
    logic [saq_pkg::ROOT_W-1:0] den_src;
    logic [SBW-1:0]             sb_src;
    logic [RW:0]                dsh;
    logic [NL-1:0]              ge;

    if (g == 0) begin : g_first
      assign vld_src  = pre_vld_r;
      assign rem_src  = pre_rem_r;
      assign quot_src = '{default: '0};
      assign ovf_src  = pre_ovf_r;
      assign den_src  = pre_den_r;
      assign sb_src   = pre_sb_r;
    end else begin : g_next
      assign vld_src  = vld_r[g-1];
      assign rem_src  = rem_r[g-1];
      assign quot_src = quot_r[g-1];
      assign ovf_src  = ovf_r[g-1];
      assign den_src  = den_r[g-1];
      assign sb_src   = sb_r[g-1];
    end

    assign dsh = (RW + 1)'(den_src) << K;

    always_comb begin
      for (int i = 0; i < NL; i++) begin
        ge[i] = (RW + 1)'(rem_src[i]) >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < NL; i++) begin
          rem_r[g][i]  <= ge[i] ? rem_src[i] - dsh[RW-1:0] : rem_src[i];
          quot_r[g][i] <= ge[i] ? (quot_src[i] | (saq_pkg::QUOT_W'(1) << K)) : quot_src[i];
        end
        ovf_r[g] <= ovf_src;
        den_r[g] <= den_src;
        sb_r[g]  <= sb_src;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_quot = quot_r[STEPS-1];
  assign out_ovf  = ovf_r[STEPS-1];
  assign out_sb   = sb_r[STEPS-1];

endmodule

// File: src/saq_prep.sv
// ----------------------------------------------------------------------------
// saq_prep
// vector magnitudes, leading shift into [2^30, 2^31], squares and their sum
// ----------------------------------------------------------------------------
module saq_prep #(
  parameter int SBW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [saq_pkg::COMP_W-1:0] in_comp [saq_pkg::LANES],
  input  logic [SBW-1:0]                    in_sb,
  output logic                              out_vld,
  output logic [saq_pkg::RAD_W-1:0]         out_rad,
  output logic [saq_pkg::COMP_W-1:0]        out_mag [saq_pkg::LANES],
  output logic [saq_pkg::LANES-1:0]         out_neg,
  output logic                              out_zero,
  output logic [SBW-1:0]                    out_sb
);

  localparam int CW = saq_pkg::COMP_W;
  localparam int NL = saq_pkg::LANES;
  localparam int SHW = $clog2(CW);

  logic [4:0]    vld_r;
  logic [CW-1:0] mag1_r [NL];
  logic [CW-1:0] max1_r;
  logic [NL-1:0] neg_r  [4];
  logic [SBW-1:0] sb_r  [5];
  logic [CW-1:0] mag2_r [NL];
  logic [SHW-1:0] sh2_r;
  logic [4:1]    zero_r;
  logic [CW-1:0] a3_r   [NL];
  logic [CW-1:0] a4_r   [NL];
  logic [saq_pkg::RAD_W-1:0] sq4_r [NL];
  logic [CW-1:0] a5_r   [NL];
  logic [NL-1:0] neg5_r;
  logic [saq_pkg::RAD_W-1:0] rad5_r;

  logic [CW-1:0] mag_nxt [NL];
  logic [CW-1:0] max_nxt;
  logic [SHW-1:0] sh_nxt;

  always_comb begin
    max_nxt = '0;
    for (int i = 0; i < NL; i++) begin
      mag_nxt[i] = in_comp[i][CW-1] ? CW'(-in_comp[i]) : CW'(in_comp[i]);
      if (mag_nxt[i] > max_nxt) begin
        max_nxt = mag_nxt[i];
      end
    end
  end

  // shift that lifts the largest magnitude to at least 2^30
  always_comb begin
    sh_nxt = '0;
    if (max1_r[CW-1:CW-2] == 2'b00) begin
      for (int i = 0; i < CW - 2; i++) begin
        if (max1_r[i]) begin
          sh_nxt = SHW'(CW - 2 - i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r   <= mag_nxt;
      max1_r   <= max_nxt;
      neg_r[0] <= {in_comp[2][CW-1], in_comp[1][CW-1], in_comp[0][CW-1]};
      sb_r[0]  <= in_sb;

      mag2_r    <= mag1_r;
      sh2_r     <= sh_nxt;
      zero_r[1] <= max1_r == '0;
      neg_r[1]  <= neg_r[0];
      sb_r[1]   <= sb_r[0];

      for (int i = 0; i < NL; i++) begin
        a3_r[i] <= mag2_r[i] << sh2_r;
      end
      zero_r[2] <= zero_r[1];
      neg_r[2]  <= neg_r[1];
      sb_r[2]   <= sb_r[1];

      for (int i = 0; i < NL; i++) begin
        sq4_r[i] <= saq_pkg::RAD_W'(a3_r[i]) * saq_pkg::RAD_W'(a3_r[i]);
      end
      a4_r      <= a3_r;
      zero_r[3] <= zero_r[2];
      neg_r[3]  <= neg_r[2];
      sb_r[3]   <= sb_r[2];

      rad5_r    <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      a5_r      <= a4_r;
      zero_r[4] <= zero_r[3];
      neg5_r    <= neg_r[3];
      sb_r[4]   <= sb_r[3];
    end
  end

  assign out_vld  = vld_r[4];
  assign out_rad  = rad5_r;
  assign out_mag  = a5_r;
  assign out_neg  = neg5_r;
  assign out_zero = zero_r[4];
  assign out_sb   = sb_r[4];

endmodule

// File: src/saq_norm.sv
// ----------------------------------------------------------------------------
// saq_norm
// vector normalizer to Q2.30: prep, square root, then rounded divide
// ----------------------------------------------------------------------------
module saq_norm #(
  parameter int SBW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [saq_pkg::COMP_W-1:0] in_comp [saq_pkg::LANES],
  input  logic [SBW-1:0]                    in_sb,
  output logic                              out_vld,
  output logic signed [saq_pkg::COMP_W-1:0] out_unit [saq_pkg::LANES],
  output logic                              out_zero,
  output logic [SBW-1:0]                    out_sb
);

  localparam int CW   = saq_pkg::COMP_W;
  localparam int NL   = saq_pkg::LANES;
  localparam int SQSB = SBW + NL * CW + NL + 1;
  localparam int DVSB = SBW + NL + 1;

  logic                      p_vld;
  logic [saq_pkg::RAD_W-1:0] p_rad;
  logic [CW-1:0]             p_mag [NL];
  logic [NL-1:0]             p_neg;
  logic                      p_zero;
  logic [SBW-1:0]            p_sb;

  saq_prep #(.SBW(SBW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_vld),
    .in_comp  (in_comp),
    .in_sb    (in_sb),
    .out_vld  (p_vld),
    .out_rad  (p_rad),
    .out_mag  (p_mag),
    .out_neg  (p_neg),
    .out_zero (p_zero),
    .out_sb   (p_sb)
  );

  logic                       r_vld;
  logic [saq_pkg::ROOT_W-1:0] r_root;
  logic [SQSB-1:0]            r_sb;

  saq_isqrt #(.SBW(SQSB)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (p_vld),
    .in_rad   (p_rad),
    .in_sb    ({p_sb, p_mag[0], p_mag[1], p_mag[2], p_neg, p_zero}),
    .out_vld  (r_vld),
    .out_root (r_root),
    .out_sb   (r_sb)
  );

  logic [saq_pkg::LANE_W-1:0] d_num [NL];
  logic                       d_vld;
  logic [saq_pkg::QUOT_W-1:0] d_quot [NL];
  logic [NL-1:0]              d_ovf;
  logic [DVSB-1:0]            d_sb;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      d_num[i] = saq_pkg::LANE_W'(r_sb[NL + 1 + (NL - 1 - i) * CW +: CW]);
    end
  end

  saq_div3 #(.SBW(DVSB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (r_vld),
    .in_num   (d_num),
    .in_den   (r_root),
    .in_sb    ({r_sb[SQSB-1 -: SBW], r_sb[NL:0]}),
    .out_vld  (d_vld),
    .out_quot (d_quot),
    .out_ovf  (d_ovf),
    .out_sb   (d_sb)
  );

  // unit components stay within 2^30, so the divider never overflows here
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      out_unit[i] = (d_sb[1 + i] && !d_ovf[i]) ? -$signed(d_quot[i]) : $signed(d_quot[i]);
    end
  end

  assign out_vld  = d_vld;
  assign out_zero = d_sb[0];
  assign out_sb   = d_sb[DVSB-1 -: SBW];

endmodule

// File: src/shortest_arc_quaternion.sv
// ----------------------------------------------------------------------------
// shortest_arc_quaternion
// rotation quaternion (Q2.30) turning start onto dest along the shortest arc
// ----------------------------------------------------------------------------
//  channel  direction  payload    handshake
//  in_      input      saq_in_t   in_valid / in_ready
//  out_     output     saq_out_t  out_valid / out_ready
//
//  one item per cycle unless a result waits on out_ready; items pass through three
//  normalizer chains in series (five prep stages, 32 square root stages, 33
//  divider stages each), four stages of products, sums, rounding and path select,
//  and the output register; rst_n clears the valid bits only; the pipeline holds
//  as a whole while a result waits on out_ready
// ----------------------------------------------------------------------------
`include "shortest_arc_quaternion_assert.svh"

module shortest_arc_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  saq_pkg::saq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output saq_pkg::saq_out_t out_data
);

  localparam int CW = saq_pkg::COMP_W;
  localparam int NL = saq_pkg::LANES;
  localparam int LW = saq_pkg::LANE_W;
  localparam int AXSB = 3 + saq_pkg::RAD_W + NL * LW + NL;
  localparam int SQSB = NL * LW + NL + 3;
  localparam int DVSB = NL + 3 + saq_pkg::ROOT_W;

  logic en;
  logic out_vld_r;
  saq_pkg::saq_out_t out_r;

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // start vector
  logic signed [CW-1:0] st_comp [NL];
  logic                 ns_vld;
  logic signed [CW-1:0] ns_unit [NL];
  logic                 ns_zero;
  logic [NL*CW-1:0]     ns_sb;

  assign st_comp[0] = in_data.start_x;
  assign st_comp[1] = in_data.start_y;
  assign st_comp[2] = in_data.start_z;

  saq_norm #(.SBW(NL * CW)) u_norm_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_comp  (st_comp),
    .in_sb    ({in_data.dest_x, in_data.dest_y, in_data.dest_z}),
    .out_vld  (ns_vld),
    .out_unit (ns_unit),
    .out_zero (ns_zero),
    .out_sb   (ns_sb)
  );

  // destination vector
  logic signed [CW-1:0] ds_comp [NL];
  logic                 nd_vld;
  logic signed [CW-1:0] nd_unit [NL];
  logic                 nd_zero;
  logic [NL*CW:0]       nd_sb;

  assign ds_comp[0] = ns_sb[3*CW-1 -: CW];
  assign ds_comp[1] = ns_sb[2*CW-1 -: CW];
  assign ds_comp[2] = ns_sb[CW-1:0];

  saq_norm #(.SBW(NL * CW + 1)) u_norm_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (ns_vld),
    .in_comp  (ds_comp),
    .in_sb    ({ns_unit[0], ns_unit[1], ns_unit[2], ns_zero}),
    .out_vld  (nd_vld),
    .out_unit (nd_unit),
    .out_zero (nd_zero),
    .out_sb   (nd_sb)
  );

  logic signed [CW-1:0] su [NL];
  assign su[0] = nd_sb[3*CW -: CW];
  assign su[1] = nd_sb[2*CW -: CW];
  assign su[2] = nd_sb[CW:1];

  // products
  logic              vld1_r, zero1_r;
  logic signed [CW-1:0] s1_r [NL];
  logic signed [63:0] pdot1_r [NL];
  logic signed [63:0] pcr1_r [6];
  logic signed [63:0] plen1_r [2];

  // sums
  logic              vld2_r, zero2_r, axsel2_r;
  logic signed [CW-1:0] s2_r [NL];
  logic signed [63:0] dot2_r;
  logic signed [63:0] cr2_r [NL];

  // rounding, opposite test, radicand of the normal path and half-turn axis
  logic              vld3_r, zero3_r, opp3_r;
  logic [saq_pkg::RAD_W-1:0] radn3_r;
  logic [LW-1:0]     crm3_r [NL];
  logic [NL-1:0]     crs3_r;
  logic signed [CW-1:0] ax3_r [NL];

  logic signed [63:0] dot_rnd;
  logic signed [33:0] cos_nxt, cosc_nxt, t_nxt;
  logic signed [63:0] cr_rnd [NL];
  logic signed [34:0] cr_nxt [NL];

  always_comb begin
    dot_rnd  = dot2_r + saq_pkg::RND_HALF;
    cos_nxt  = 34'(dot_rnd >>> saq_pkg::FRAC);
    cosc_nxt = (cos_nxt > saq_pkg::COS_MAX) ? saq_pkg::COS_MAX : cos_nxt;
    t_nxt    = (cosc_nxt + saq_pkg::COS_MAX) <<< 1;
    for (int i = 0; i < NL; i++) begin
      cr_rnd[i] = cr2_r[i] + saq_pkg::RND_HALF;
      cr_nxt[i] = 35'(cr_rnd[i] >>> saq_pkg::FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= nd_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1_r <= nd_zero || nd_sb[0];
      s1_r    <= su;
      for (int i = 0; i < NL; i++) begin
        pdot1_r[i] <= 64'(su[i]) * 64'(nd_unit[i]);
      end
      pcr1_r[0]  <= 64'(su[1]) * 64'(nd_unit[2]);
      pcr1_r[1]  <= 64'(su[2]) * 64'(nd_unit[1]);
      pcr1_r[2]  <= 64'(su[2]) * 64'(nd_unit[0]);
      pcr1_r[3]  <= 64'(su[0]) * 64'(nd_unit[2]);
      pcr1_r[4]  <= 64'(su[0]) * 64'(nd_unit[1]);
      pcr1_r[5]  <= 64'(su[1]) * 64'(nd_unit[0]);
      plen1_r[0] <= 64'(su[0]) * 64'(su[0]);
      plen1_r[1] <= 64'(su[1]) * 64'(su[1]);

      zero2_r  <= zero1_r;
      s2_r     <= s1_r;
      dot2_r   <= pdot1_r[0] + pdot1_r[1] + pdot1_r[2];
      cr2_r[0] <= pcr1_r[0] - pcr1_r[1];
      cr2_r[1] <= pcr1_r[2] - pcr1_r[3];
      cr2_r[2] <= pcr1_r[4] - pcr1_r[5];
      axsel2_r <= $unsigned(plen1_r[0] + plen1_r[1]) < saq_pkg::AXIS_MIN;

      zero3_r <= zero2_r;
      opp3_r  <= cos_nxt < saq_pkg::OPP_LIM;
      radn3_r <= saq_pkg::RAD_W'({t_nxt[32:0], 30'd0});
      for (int i = 0; i < NL; i++) begin
        crs3_r[i] <= cr_nxt[i][34];
        crm3_r[i] <= cr_nxt[i][34] ? LW'(-cr_nxt[i]) : LW'(cr_nxt[i]);
      end
      if (axsel2_r) begin
        ax3_r[0] <= '0;
        ax3_r[1] <= -s2_r[2];
        ax3_r[2] <= s2_r[1];
      end else begin
        ax3_r[0] <= -s2_r[1];
        ax3_r[1] <= s2_r[0];
        ax3_r[2] <= '0;
      end
    end
  end

  // axis prep runs for every item, normal-path values ride along
  logic                      pa_vld;
  logic [saq_pkg::RAD_W-1:0] pa_rad;
  logic [CW-1:0]             pa_mag [NL];
  logic [NL-1:0]             pa_neg;
  logic                      pa_zero;
  logic [AXSB-1:0]           pa_sb;

  saq_prep #(.SBW(AXSB)) u_prep_ax (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld3_r),
    .in_comp  (ax3_r),
    .in_sb    ({opp3_r, zero3_r, 1'b0, radn3_r, crm3_r[0], crm3_r[1], crm3_r[2], crs3_r}),
    .out_vld  (pa_vld),
    .out_rad  (pa_rad),
    .out_mag  (pa_mag),
    .out_neg  (pa_neg),
    .out_zero (pa_zero),
    .out_sb   (pa_sb)
  );

  logic pa_opp, pa_zin;
  assign pa_opp = pa_sb[AXSB-1];
  assign pa_zin = pa_sb[AXSB-2] | pa_sb[AXSB-3];

  // path select
  logic                      vld4_r, opp4_r, zero4_r, zax4_r;
  logic [saq_pkg::RAD_W-1:0] rad4_r;
  logic [LW-1:0]             num4_r [NL];
  logic [NL-1:0]             neg4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= pa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opp4_r  <= pa_opp;
      zero4_r <= pa_zin;
      zax4_r  <= pa_zero;
      rad4_r  <= pa_opp ? pa_rad : pa_sb[NL*LW+NL +: saq_pkg::RAD_W];
      neg4_r  <= pa_opp ? pa_neg : pa_sb[NL-1:0];
      for (int i = 0; i < NL; i++) begin
        num4_r[i] <= pa_opp ? LW'(pa_mag[i]) : pa_sb[NL + (NL - 1 - i) * LW +: LW];
      end
    end
  end

  logic                       q_vld;
  logic [saq_pkg::ROOT_W-1:0] q_root;
  logic [SQSB-1:0]            q_sb;

  saq_isqrt #(.SBW(SQSB)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld4_r),
    .in_rad   (rad4_r),
    .in_sb    ({num4_r[0], num4_r[1], num4_r[2], neg4_r, opp4_r, zero4_r, zax4_r}),
    .out_vld  (q_vld),
    .out_root (q_root),
    .out_sb   (q_sb)
  );

  logic [LW-1:0]              v_num [NL];
  logic                       v_vld;
  logic [saq_pkg::QUOT_W-1:0] v_quot [NL];
  logic [NL-1:0]              v_ovf;
  logic [DVSB-1:0]            v_sb;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      v_num[i] = q_sb[NL + 3 + (NL - 1 - i) * LW +: LW];
    end
  end

  saq_div3 #(.SBW(DVSB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (q_vld),
    .in_num   (v_num),
    .in_den   (q_root),
    .in_sb    ({q_sb[NL+2:0], q_root}),
    .out_vld  (v_vld),
    .out_quot (v_quot),
    .out_ovf  (v_ovf),
    .out_sb   (v_sb)
  );

  // result assembly with saturation
  logic [saq_pkg::ROOT_W-1:0] v_root;
  logic [NL-1:0]              v_neg;
  logic                       v_opp, v_zero, v_zax;
  logic signed [CW-1:0]       v_part [NL];
  logic [saq_pkg::ROOT_W:0]   w_sum;
  saq_pkg::saq_out_t          out_nxt;

  assign v_root = v_sb[saq_pkg::ROOT_W-1:0];
  assign v_zax  = v_sb[saq_pkg::ROOT_W];
  assign v_zero = v_sb[saq_pkg::ROOT_W+1];
  assign v_opp  = v_sb[saq_pkg::ROOT_W+2];
  assign v_neg  = v_sb[DVSB-1 -: NL];
  assign w_sum  = (saq_pkg::ROOT_W + 1)'(v_root) + 1'b1;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (!v_neg[i]) begin
        v_part[i] = (v_ovf[i] || v_quot[i][CW-1]) ? 32'sh7fffffff : $signed(v_quot[i]);
      end else if (v_ovf[i] || (v_quot[i][CW-1] && v_quot[i][CW-2:0] != '0)) begin
        v_part[i] = 32'sh80000000;
      end else begin
        v_part[i] = -$signed(v_quot[i]);
      end
      if (v_zero || (v_opp && v_zax)) begin
        v_part[i] = '0;
      end
    end
    out_nxt.quat_x        = v_part[0];
    out_nxt.quat_y        = v_part[1];
    out_nxt.quat_z        = v_part[2];
    out_nxt.opposite_case = v_opp && !v_zero;
    out_nxt.zero_length   = v_zero;
    if (v_zero) begin
      out_nxt.quat_w = saq_pkg::ONE_Q30;
    end else if (v_opp) begin
      out_nxt.quat_w = '0;
    end else begin
      out_nxt.quat_w = $signed(w_sum[saq_pkg::ROOT_W:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `SAQ_ASSERT_IMP(a_zero_identity, out_valid && out_data.zero_length, !out_data.opposite_case && out_data.quat_w == saq_pkg::ONE_Q30 && out_data.quat_x == '0, "zero-length result is not the identity")
  `SAQ_ASSERT_IMP(a_half_turn_w, out_valid && out_data.opposite_case, out_data.quat_w == '0 && !out_data.zero_length, "half-turn result has nonzero w")
  `SAQ_ASSERT_IMP(a_arc_w_positive, out_valid && !out_data.opposite_case && !out_data.zero_length, !out_data.quat_w[31], "shortest-arc w is negative")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// shortest arc quaternion testbench
// drives vector pairs through the valid/ready channels, predicts each quaternion
// not given directly with an integer model of normalization, dot, cross and the
// half-turn path, and compares every result transfer field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int    N_RANDOM  = 950;
  localparam int    LATENCY   = 220;
  localparam longint ONE      = 64'sd1073741824;

  typedef struct {
    saq_pkg::saq_in_t  stim;
    bit                typed;
    saq_pkg::saq_out_t want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  saq_pkg::saq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  saq_pkg::saq_out_t out_data;

  saq_pkg::saq_out_t quat_q[$];
  int       mismatches = 0;
  bit       tail = 1'b0;
  row_t     rows[$];

  shortest_arc_quaternion u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint rnd30(longint v);
    return (v >>> 30) + ((v >> 29) & 1);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit unit_vec(input longint c[3], output longint u[3]);
    longint unsigned a[3], m, l2, r, q;
    m = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag(c[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      u = '{0, 0, 0};
      return 0;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) l2 += a[i] * a[i];
    r = root64(l2);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (r >> 1)) / r;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic saq_pkg::saq_out_t shortest_arc(saq_pkg::saq_in_t v);
    longint sv[3], dv[3], s[3], d[3], cr[3], ax[3], un[3], cosv, t;
    longint unsigned sq, q, len2;
    bit oks, okd;
    saq_pkg::saq_out_t o;
    sv = '{longint'(v.start_x), longint'(v.start_y), longint'(v.start_z)};
    dv = '{longint'(v.dest_x), longint'(v.dest_y), longint'(v.dest_z)};
    oks = unit_vec(sv, s);
    okd = unit_vec(dv, d);
    o = '0;
    if (!oks || !okd) begin
      o.quat_w = ONE;
      o.zero_length = 1'b1;
      return o;
    end
    cosv = rnd30(s[0] * d[0] + s[1] * d[1] + s[2] * d[2]);
    if (cosv < -ONE + 1073742) begin
      len2 = s[0] * s[0] + s[1] * s[1];
      if (len2 < saq_pkg::AXIS_MIN) ax = '{0, -s[2], s[1]};
      else ax = '{-s[1], s[0], 0};
      void'(unit_vec(ax, un));
      o.quat_x = clip32(un[0]);
      o.quat_y = clip32(un[1]);
      o.quat_z = clip32(un[2]);
      o.opposite_case = 1'b1;
      return o;
    end
    cr[0] = rnd30(s[1] * d[2] - s[2] * d[1]);
    cr[1] = rnd30(s[2] * d[0] - s[0] * d[2]);
    cr[2] = rnd30(s[0] * d[1] - s[1] * d[0]);
    if (cosv > ONE) cosv = ONE;
    t = 2 * (ONE + cosv);
    sq = root64(longint'(t) << 30);
    for (int i = 0; i < 3; i++) begin
      q = ((mag(cr[i]) << 30) + (sq >> 1)) / sq;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      cr[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
    end
    o.quat_w = clip32(longint'((sq + 1) >> 1));
    o.quat_x = clip32(cr[0]);
    o.quat_y = clip32(cr[1]);
    o.quat_z = clip32(cr[2]);
    return o;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 2) - 1;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed(32'($urandom)) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic saq_pkg::saq_in_t rand_pair();
    saq_pkg::saq_in_t v;
    v.start_x = rand_comp();
    v.start_y = rand_comp();
    v.start_z = rand_comp();
    case ($urandom_range(0, 9))
      0, 1: begin
        // nearly antiparallel
        v.dest_x = -(v.start_x >>> 1) + $signed(32'($urandom_range(0, 6)) - 3);
        v.dest_y = -(v.start_y >>> 1) + $signed(32'($urandom_range(0, 6)) - 3);
        v.dest_z = -(v.start_z >>> 1) + $signed(32'($urandom_range(0, 6)) - 3);
      end
      2: begin
        v.dest_x = v.start_x;
        v.dest_y = v.start_y;
        v.dest_z = v.start_z;
      end
      3: begin
        // start near the z axis, exercising the x-axis fallback
        v.start_x = $signed(32'($urandom_range(0, 2000))) - 1000;
        v.start_y = $signed(32'($urandom_range(0, 2000))) - 1000;
        v.start_z = $urandom_range(0, 1) ? 32'sh00100000 : -32'sh00100000;
        v.dest_x = -v.start_x;
        v.dest_y = -v.start_y;
        v.dest_z = -v.start_z;
      end
      default: begin
        v.dest_x = rand_comp();
        v.dest_y = rand_comp();
        v.dest_z = rand_comp();
      end
    endcase
    if ($urandom_range(0, 40) == 0) {v.start_x, v.start_y, v.start_z} = '0;
    if ($urandom_range(0, 40) == 0) {v.dest_x, v.dest_y, v.dest_z} = '0;
    return v;
  endfunction

  task automatic add_row(saq_pkg::saq_in_t v, bit typed, saq_pkg::saq_out_t want);
    row_t r;
    r.stim = v;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic send(saq_pkg::saq_in_t v, saq_pkg::saq_out_t want);
    int gap;
    if (!tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    quat_q.push_back(want);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    saq_pkg::saq_in_t  v;
    saq_pkg::saq_out_t ident, ht;
    ident = '0;
    ident.quat_w = ONE;
    ident.zero_length = 1'b1;
    ht = '0;
    ht.quat_x = -ONE;
    ht.opposite_case = 1'b1;
    add_row('0, 1, ident);
    add_row('{32'sh10000, 0, 0, 0, 0, 0}, 1, ident);
    add_row('{0, 0, 0, 0, 32'sh7fffffff, 0}, 1, ident);
    // antiparallel along y: axis is cross(z, start)
    add_row('{0, 32'sh10000, 0, 0, -32'sh10000, 0}, 1, ht);
    add_row('{32'sh10000, 0, 0, 32'sh10000, 0, 0}, 1, '{ONE, 0, 0, 0, 0, 0});
    add_row('{0, 0, 32'sh10000, 0, 0, -32'sh10000}, 0, '0);
    add_row('{0, 0, -32'sh80000000, 0, 0, 32'sh7fffffff}, 0, '0);
    add_row('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              -32'sh80000000, -32'sh80000000, -32'sh80000000}, 0, '0);
    add_row('{-32'sh80000000, 32'sh7fffffff, 1, 1, -1, -32'sh80000000}, 0, '0);
    add_row('{1, 0, 0, 0, 1, 0}, 0, '0);
    add_row('{-1, -1, -1, -1, -1, -1}, 0, '0);
    add_row('{32'sh10000, 0, 0, -32'sh10000, 32'sh41, 0}, 0, '0);
    add_row('{32'sh10000, 0, 0, -32'sh10000, 32'sh2000, 0}, 0, '0);
    add_row('{32'sh55555555, -32'sh2aaaaaab, 32'sh12345678,
              -32'sh55555555, 32'sh2aaaaaab, -32'sh12345678}, 0, '0);
    add_row('{32'sh00000010, 0, 32'sh10000000, -32'sh10, 0, -32'sh10000000}, 0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send(rows[i].stim, rows[i].typed ? rows[i].want : shortest_arc(rows[i].stim));
    drain();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM * 4 / 5) tail = 1'b1;
      if (i == N_RANDOM / 2) drain();
      v = rand_pair();
      send(v, shortest_arc(v));
    end
    drain();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    int stall;
    forever begin
      if (!tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result transfer check
  always @(posedge clk) begin
    saq_pkg::saq_out_t exp_q;
    if (rst_n && out_valid && out_ready) begin
      if (quat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_q = quat_q.pop_front();
        if (out_data !== exp_q) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch w/x/y/z/opp/zero expected %0d %0d %0d %0d %b %b, got %0d %0d %0d %0d %b %b",
                     exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                     exp_q.opposite_case, exp_q.zero_length,
                     out_data.quat_w, out_data.quat_x, out_data.quat_y,
                     out_data.quat_z, out_data.opposite_case, out_data.zero_length);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
